FILE: rtl/skt_pkg.sv
`default_nettype none
package skt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 17;
    localparam int TAG_W       = 16;
    localparam int MODE_W      = 2;
    localparam int ENTRY_W     = KEY_W + TAG_W;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DECIDE,
        ST_SHIFT,
        ST_SHIFT_END,
        ST_PUT,
        ST_FETCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic srch_issue;
        logic srch_cmp;
        logic shift_init;
        logic shift_step;
        logic shift_flush;
        logic put;
        logic fetch;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              full;
        logic              empty;
        logic              is_insert;
        logic              srch_more;
        logic              need_shift;
        logic              shift_last;
        logic              fetch_needed;
        logic              out_busy;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/skt_ram.sv
`default_nettype none
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/skt_ctrl.sv
`default_nettype none
module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if ((status.in_mode == MODE_INSERT && !status.full)
                        || status.in_mode == MODE_FIND)
                    begin
                        state_next = status.empty ? ST_DECIDE : ST_SRCH_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (!status.srch_more)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.is_insert)
                begin
                    state_next = status.need_shift ? ST_SHIFT : ST_PUT;
                end
                else
                begin
                    state_next = status.fetch_needed ? ST_FETCH : ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (status.shift_last)
                begin
                    state_next = ST_SHIFT_END;
                end
            end
            ST_SHIFT_END:
            begin
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SRCH_RD:
            begin
                cmd.srch_issue = 1'b1;
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.shift_init = status.is_insert && status.need_shift;
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
            end
            ST_SHIFT_END:
            begin
                cmd.shift_flush = 1'b1;
            end
            ST_PUT:
            begin
                cmd.put = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_DONE:
            begin
                cmd.res_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/skt_datapath.sv
`default_nettype none
module skt_datapath
    import skt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic [MODE_W-1:0] in_mode,
    input  wire logic [KEY_W-1:0]  in_key,
    input  wire logic [TAG_W-1:0]  in_tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CNT_W-1:0]       out_position,
    output logic [TAG_W-1:0]       out_hit_tag,
    output logic                   out_hit_valid,
    output logic [CNT_W-1:0]       out_entry_count,
    output logic                   out_refused
);

    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              refuse_reg;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  lo_reg,     lo_next;
    logic [CNT_W-1:0]  hi_reg,     hi_next;
    logic [CNT_W-1:0]  idx_reg,    idx_next;
    logic [ADDR_W-1:0] sh_ptr_reg;
    logic [ADDR_W-1:0] sh_src_reg;
    logic              sh_first_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  position_reg;
    logic [TAG_W-1:0]  hit_tag_reg;
    logic              hit_valid_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    logic              refused_reg;

    logic [CNT_W-1:0]   mid_cur;
    logic [CNT_W-1:0]   mid_nxt;
    logic               done_next;
    logic [KEY_W-1:0]   rd_key;
    logic [TAG_W-1:0]   rd_tag;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               find_hit;

    assign rd_key  = ram_rdata[ENTRY_W-1:TAG_W];
    assign rd_tag  = ram_rdata[TAG_W-1:0];
    assign mid_cur = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_nxt = lo_next + ((hi_next - lo_next) >> 1);

    // one bisection step on the key just read
    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        idx_next  = mid_cur;
        done_next = 1'b0;
        if (mode_reg == MODE_INSERT)
        begin
            if (key_reg > rd_key)
            begin
                if (lo_reg == mid_cur)
                begin
                    idx_next  = mid_cur + CNT_W'(1);
                    done_next = 1'b1;
                end
                else
                begin
                    lo_next = mid_cur;
                end
            end
            else if (key_reg < rd_key)
            begin
                hi_next = mid_cur;
            end
            else
            begin
                done_next = 1'b1;
            end
        end
        else
        begin
            idx_next = idx_reg;
            if (rd_key < key_reg)
            begin
                lo_next = mid_cur + CNT_W'(1);
            end
            else
            begin
                hi_next = mid_cur;
            end
        end
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = sh_ptr_reg;
        if (cmd.srch_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = mid_cur[ADDR_W-1:0];
        end
        else if (cmd.srch_cmp)
        begin
            ram_re    = 1'b1;
            ram_raddr = mid_nxt[ADDR_W-1:0];
        end
        else if (cmd.shift_step)
        begin
            ram_re    = 1'b1;
            ram_raddr = sh_ptr_reg;
        end
        else if (cmd.fetch)
        begin
            ram_re    = 1'b1;
            ram_raddr = lo_reg[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sh_src_reg + ADDR_W'(1);
        ram_wdata = ram_rdata;
        if ((cmd.shift_step && !sh_first_reg) || cmd.shift_flush)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.put)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[ADDR_W-1:0];
            ram_wdata = {key_reg, tag_reg};
        end
    end

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= in_mode;
            key_reg    <= in_key;
            tag_reg    <= in_tag;
            refuse_reg <= (in_mode == MODE_INSERT) && status.full;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
            idx_reg    <= count_reg;
        end
        else if (cmd.srch_cmp)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            idx_reg <= idx_next;
        end
        if (cmd.shift_init)
        begin
            sh_ptr_reg   <= ADDR_W'(count_reg - CNT_W'(1));
            sh_first_reg <= 1'b1;
        end
        else if (cmd.shift_step)
        begin
            sh_src_reg   <= sh_ptr_reg;
            sh_ptr_reg   <= sh_ptr_reg - ADDR_W'(1);
            sh_first_reg <= 1'b0;
        end
    end

    assign find_hit = lo_reg < count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.put)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.res_load && mode_reg == MODE_CLEAR)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            position_reg    <= '0;
            hit_tag_reg     <= '0;
            hit_valid_reg   <= 1'b0;
            entry_count_reg <= count_next;
            refused_reg     <= 1'b0;
            case (mode_reg)
                MODE_INSERT:
                begin
                    if (refuse_reg)
                    begin
                        position_reg <= count_reg;
                        refused_reg  <= 1'b1;
                    end
                    else
                    begin
                        position_reg  <= idx_reg;
                        hit_tag_reg   <= tag_reg;
                        hit_valid_reg <= 1'b1;
                    end
                end
                MODE_FIND:
                begin
                    position_reg  <= lo_reg;
                    hit_valid_reg <= find_hit;
                    hit_tag_reg   <= find_hit ? rd_tag : '0;
                end
                default:
                begin
                    position_reg <= '0;
                end
            endcase
        end
    end

    always_comb
    begin
        status.in_mode      = in_mode;
        status.full         = count_reg == CNT_W'(TABLE_DEPTH);
        status.empty        = count_reg == '0;
        status.is_insert    = mode_reg == MODE_INSERT;
        status.srch_more    = !done_next && (hi_next > lo_next);
        status.need_shift   = count_reg > idx_reg;
        status.shift_last   = sh_ptr_reg == idx_reg[ADDR_W-1:0];
        status.fetch_needed = find_hit;
        status.out_busy     = out_valid_reg && !out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_position    = position_reg;
    assign out_hit_tag     = hit_tag_reg;
    assign out_hit_valid   = hit_valid_reg;
    assign out_entry_count = entry_count_reg;
    assign out_refused     = refused_reg;

endmodule
`default_nettype wire

FILE: rtl/sorted_key_table_core.sv
`default_nettype none
// Sorted key table: up to 1024 entries (key, tag) kept in ascending key order in one
// single-port-write, registered-read RAM. One request is handled at a time. A find is a
// bisection search with one RAM read per step. An insert runs the same search, then
// moves every entry at or above the insertion point up by one and writes the new entry;
// the move rate is one entry per cycle over the RAM's one read and one write port. A
// clear, an ignored mode or a refused insert skips the search and goes to the result.
// The result sits in an output register, so the next request is taken while it waits.
module sorted_key_table_core
    import skt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // key[16:0], tag[32:17], zero fill
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // position[10:0], hit_tag[26:11], hit_valid[27],
                                        // entry_count[38:28], refused[39]
);

    cmd_t             cmd;
    status_t          status;
    logic [CNT_W-1:0] position;
    logic [TAG_W-1:0] hit_tag;
    logic             hit_valid;
    logic [CNT_W-1:0] entry_count;
    logic             refused;

    skt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skt_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_mode         (s_tuser),
        .in_key          (s_tdata[KEY_W-1:0]),
        .in_tag          (s_tdata[KEY_W+TAG_W-1:KEY_W]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_position    (position),
        .out_hit_tag     (hit_tag),
        .out_hit_valid   (hit_valid),
        .out_entry_count (entry_count),
        .out_refused     (refused)
    );

    assign m_tdata = {refused, entry_count, hit_valid, hit_tag, position};

    a_single_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.put, cmd.shift_step, cmd.shift_flush}))
        else $error("more than one ram write command");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(m_tvalid && !m_tready))
        else $error("result loaded over a pending one");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    a_refused_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && refused) |-> (!hit_valid && position == entry_count))
        else $error("refused insert with bad result fields");

endmodule
`default_nettype wire
